// File: hdl/swap_slot_bitmap_allocator_assert.svh
// Assertion macros shared by the allocator's RTL.
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWSA_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWSA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: hdl/swsa_pkg.sv
package swsa_pkg;

	// Default sizes of the slot map and of a page.
	localparam int SLOTS_DEFAULT = 1024;
	localparam int SECTORS_DEFAULT = 8;

	// The bitmap is kept in rows of this many slots.
	localparam int ROW_BITS = 32;
	localparam int ROW_BIT_W = 5;

	// Field widths fixed by the interface.
	localparam int CMD_W = 2;
	localparam int INDEX_W = 10;
	localparam int STATUS_W = 3;
	localparam int OP_W = 2;
	localparam int ADDR_W = 13;
	localparam int COUNT_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 1;

	// Command queue between dispatch and execution.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	localparam logic [CMD_W-1:0] CMD_OUT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_IN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_DEVICE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

	localparam logic [OP_W-1:0] OP_NONE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SWAP_PRESENT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 1'd1;

	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_OUT,
		KIND_IN,
		KIND_FREE
	} kind_t;

	// One queued command after dispatch.
	typedef struct packed {
		kind_t kind;
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0] slot;
	} entry_t;

	typedef struct packed {
		logic present;
		logic [COUNT_W-1:0] count;
	} cfg_t;

endpackage

// File: hdl/swsa_front.sv
module swsa_front #(
	parameter int SLOTS = swsa_pkg::SLOTS_DEFAULT
) (
	input  logic                           accept,
	input  logic [swsa_pkg::CMD_W-1:0]     cmd,
	input  logic [swsa_pkg::INDEX_W-1:0]   slot_index,
	input  swsa_pkg::cfg_t                 cfg,
	output logic                           push,
	output swsa_pkg::entry_t               entry
);

	logic out_of_range;

	// An index must sit below both the programmed count and the map size.
	assign out_of_range = ({1'b0, slot_index} >= cfg.count) ||
		(32'(slot_index) >= 32'(SLOTS));

	always_comb begin
		push = accept && (cmd != swsa_pkg::CMD_NONE);
		entry.kind = swsa_pkg::KIND_ERR;
		entry.status = swsa_pkg::ST_OK;
		entry.slot = slot_index;
		if (!cfg.present) begin
			entry.status = swsa_pkg::ST_NO_DEVICE;
			if (cmd == swsa_pkg::CMD_OUT) begin
				entry.slot = '0;
			end
		end else if (cmd == swsa_pkg::CMD_OUT) begin
			entry.kind = swsa_pkg::KIND_OUT;
		end else if (out_of_range) begin
			entry.status = swsa_pkg::ST_RANGE;
		end else if (cmd == swsa_pkg::CMD_IN) begin
			entry.kind = swsa_pkg::KIND_IN;
		end else begin
			entry.kind = swsa_pkg::KIND_FREE;
		end
	end

endmodule

// File: hdl/swsa_queue.sv
module swsa_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  swsa_pkg::entry_t push_entry,
	input  logic             pop,
	output swsa_pkg::entry_t head,
	output logic             empty,
	output logic             full
);

	swsa_pkg::entry_t slots_q [swsa_pkg::QUEUE_DEPTH];
	logic [swsa_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [swsa_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [swsa_pkg::QUEUE_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == swsa_pkg::QUEUE_CNT_W'(swsa_pkg::QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/swsa_back.sv
module swsa_back #(
	parameter int SLOTS = swsa_pkg::SLOTS_DEFAULT,
	parameter int SECTORS_PER_SLOT = swsa_pkg::SECTORS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swsa_pkg::cfg_t                  cfg,
	input  logic                            empty,
	input  swsa_pkg::entry_t                head,
	output logic                            pop,
	output logic                            result_valid,
	output logic [swsa_pkg::STATUS_W-1:0]   status,
	output logic [swsa_pkg::INDEX_W-1:0]    slot_number,
	output logic [swsa_pkg::OP_W-1:0]       sector_op,
	output logic [swsa_pkg::ADDR_W-1:0]     sector_address,
	output logic                            last
);

	localparam int ROWS = (SLOTS + swsa_pkg::ROW_BITS - 1) / swsa_pkg::ROW_BITS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SLOT_W = ROW_W + swsa_pkg::ROW_BIT_W;
	localparam int SEC_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTORS_PER_SLOT - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [swsa_pkg::ROW_BITS-1:0] mem [ROWS];
	logic [swsa_pkg::ROW_BITS-1:0] rdata_s1;
	logic [ROWS-1:0] row_valid_q;
	logic [ROWS-1:0] row_full_q;

	logic [1:0] state_q;
	swsa_pkg::kind_t kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [swsa_pkg::OP_W-1:0] op_q;
	logic [swsa_pkg::ADDR_W-1:0] base_q;
	logic [SEC_W-1:0] sec_q;

	logic [ROW_W-1:0] free_row;
	logic any_free;
	logic [ROW_W-1:0] cur_row;
	logic [swsa_pkg::ROW_BIT_W-1:0] cur_bit;
	logic [swsa_pkg::ROW_BITS-1:0] word;
	logic [swsa_pkg::ROW_BIT_W-1:0] zero_bit;
	logic zero_found;
	logic [SLOT_W-1:0] cand_slot;
	logic cand_bad;
	logic [31:0] base_full;

	logic rd_en;
	logic [ROW_W-1:0] rd_row;
	logic wr_en;
	logic [swsa_pkg::ROW_BITS-1:0] wr_word;

	logic [1:0] state_d;
	logic [SLOT_W-1:0] slot_d;
	logic [swsa_pkg::OP_W-1:0] op_d;
	logic res_v;
	logic [swsa_pkg::STATUS_W-1:0] res_status;
	logic [swsa_pkg::INDEX_W-1:0] res_slot;
	logic [swsa_pkg::OP_W-1:0] res_op;
	logic [swsa_pkg::ADDR_W-1:0] res_addr;
	logic res_last;

	assign cur_row = slot_q[SLOT_W-1:swsa_pkg::ROW_BIT_W];
	assign cur_bit = slot_q[swsa_pkg::ROW_BIT_W-1:0];
	assign word = row_valid_q[cur_row] ? rdata_s1 : '0;
	assign cand_slot = {cur_row, zero_bit};
	assign cand_bad = !zero_found || (32'(cand_slot) >= 32'(cfg.count)) ||
		(32'(cand_slot) >= 32'(SLOTS));
	assign base_full = 32'(slot_d) * 32'(SECTORS_PER_SLOT);

	// Lowest row that still has a free slot.
	always_comb begin
		free_row = '0;
		any_free = 1'b0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (!row_full_q[i]) begin
				free_row = ROW_W'(i);
				any_free = 1'b1;
			end
		end
	end

	// Lowest clear bit within the row that was read.
	always_comb begin
		zero_bit = '0;
		zero_found = 1'b0;
		for (int b = swsa_pkg::ROW_BITS - 1; b >= 0; b--) begin
			if (!word[b]) begin
				zero_bit = swsa_pkg::ROW_BIT_W'(b);
				zero_found = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		slot_d = slot_q;
		op_d = op_q;
		pop = 1'b0;
		rd_en = 1'b0;
		rd_row = '0;
		wr_en = 1'b0;
		wr_word = word;
		res_v = 1'b0;
		res_status = swsa_pkg::ST_OK;
		res_slot = swsa_pkg::INDEX_W'(slot_q);
		res_op = swsa_pkg::OP_NONE;
		res_addr = '0;
		res_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					slot_d = SLOT_W'(head.slot);
					unique case (head.kind)
						swsa_pkg::KIND_ERR: begin
							res_v = 1'b1;
							res_status = head.status;
							res_slot = head.slot;
						end
						swsa_pkg::KIND_OUT: begin
							if (any_free) begin
								slot_d = {free_row, swsa_pkg::ROW_BIT_W'(0)};
								rd_en = 1'b1;
								rd_row = free_row;
								state_d = S_READ;
							end else begin
								res_v = 1'b1;
								res_status = swsa_pkg::ST_NO_SLOT;
								res_slot = '0;
							end
						end
						swsa_pkg::KIND_IN, swsa_pkg::KIND_FREE: begin
							rd_en = 1'b1;
							rd_row = slot_d[SLOT_W-1:swsa_pkg::ROW_BIT_W];
							state_d = S_READ;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_IDLE;
				unique case (kind_q)
					swsa_pkg::KIND_OUT: begin
						if (cand_bad) begin
							res_v = 1'b1;
							res_status = swsa_pkg::ST_NO_SLOT;
							res_slot = '0;
						end else begin
							wr_en = 1'b1;
							wr_word = word | (swsa_pkg::ROW_BITS'(1) << zero_bit);
							slot_d = cand_slot;
							op_d = swsa_pkg::OP_WRITE;
							state_d = S_EMIT;
						end
					end
					swsa_pkg::KIND_IN: begin
						if (!word[cur_bit]) begin
							res_v = 1'b1;
							res_status = swsa_pkg::ST_NOT_USED;
						end else begin
							wr_en = 1'b1;
							wr_word = word & ~(swsa_pkg::ROW_BITS'(1) << cur_bit);
							op_d = swsa_pkg::OP_READ;
							state_d = S_EMIT;
						end
					end
					default: begin
						// Free: clear the bit whether or not it was set.
						wr_en = 1'b1;
						wr_word = word & ~(swsa_pkg::ROW_BITS'(1) << cur_bit);
						res_v = 1'b1;
					end
				endcase
			end
			S_EMIT: begin
				res_v = 1'b1;
				res_op = op_q;
				res_addr = base_q + swsa_pkg::ADDR_W'(sec_q);
				res_last = (sec_q == SEC_LAST);
				if (sec_q == SEC_LAST) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cur_row] <= wr_word;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_row];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
		end
		slot_q <= slot_d;
		op_q <= op_d;
		if (state_q == S_READ) begin
			base_q <= base_full[swsa_pkg::ADDR_W-1:0];
		end
		status <= res_status;
		slot_number <= res_slot;
		sector_op <= res_op;
		sector_address <= res_addr;
		last <= res_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sec_q <= '0;
			row_valid_q <= '0;
			row_full_q <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= res_v;
			if (state_q == S_EMIT) begin
				sec_q <= sec_q + 1'b1;
			end else begin
				sec_q <= '0;
			end
			if (wr_en) begin
				row_valid_q[cur_row] <= 1'b1;
				row_full_q[cur_row] <= &wr_word;
			end
		end
	end

endmodule

// File: hdl/swap_slot_bitmap_allocator.sv
// Each command passes through the queue to the back end, which settles a status known
// when the command leaves the queue at once, reads the slot map row for a free or for a
// status found there, and then emits the sector burst for a swap in or out.
// The back end finishes one command before it takes the next from the queue; results
// cannot be stalled.
// Reset clears the control registers and marks every slot free at once (row valid bits).
module swap_slot_bitmap_allocator #(
	parameter int SLOTS = swsa_pkg::SLOTS_DEFAULT,
	parameter int SECTORS_PER_SLOT = swsa_pkg::SECTORS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [swsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [swsa_pkg::CMD_W-1:0]          cmd,
	input  logic [swsa_pkg::INDEX_W-1:0]        slot_index,
	output logic                                result_valid,
	output logic [swsa_pkg::STATUS_W-1:0]       status,
	output logic [swsa_pkg::INDEX_W-1:0]        slot_number,
	output logic [swsa_pkg::OP_W-1:0]           sector_op,
	output logic [swsa_pkg::ADDR_W-1:0]         sector_address,
	output logic                                last
);

	`include "swap_slot_bitmap_allocator_assert.svh"

	// The front end classifies each command against the configuration as it
	// arrives: disabled device, out-of-range index and the unknown command are
	// settled here, so the back end only ever touches the bitmap for real work.
	// A two-entry queue sits between them; busy is simply the queue being full,
	// so new commands keep arriving while a sector burst is still going out.
	//
	// The back end keeps the used bits in a memory of 32-bit rows plus one
	// "row full" flag per row. The full flags point straight at the first row
	// holding a free slot, one registered row read finds the lowest clear bit,
	// and the updated row is written back in the following cycle. A free slot
	// found at or above the usable count means there is nothing to allocate.

	swsa_pkg::cfg_t cfg_q;
	swsa_pkg::entry_t push_entry;
	swsa_pkg::entry_t head;
	logic accept;
	logic push;
	logic pop;
	logic empty;
	logic full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swsa_pkg::REG_SWAP_PRESENT: cfg_q.present <= cfg_data[0];
				swsa_pkg::REG_SLOT_COUNT: cfg_q.count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = full;
	assign accept = start && !busy;

	swsa_front #(
		.SLOTS(SLOTS)
	) u_front (
		.accept(accept),
		.cmd(cmd),
		.slot_index(slot_index),
		.cfg(cfg_q),
		.push(push),
		.entry(push_entry)
	);

	swsa_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	swsa_back #(
		.SLOTS(SLOTS),
		.SECTORS_PER_SLOT(SECTORS_PER_SLOT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.empty(empty),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.status(status),
		.slot_number(slot_number),
		.sector_op(sector_op),
		.sector_address(sector_address),
		.last(last)
	);

	// A sector burst runs without gaps until its last beat.
	`SWSA_ASSERT_NEXT(a_burst_contiguous, clk, arst_n, result_valid && !last, result_valid, "sector burst broke off before its last beat")

	// Consecutive beats of a burst address consecutive sectors of one slot.
	`SWSA_ASSERT_NEXT(a_burst_addr_step, clk, arst_n, result_valid && !last, (sector_address == $past(sector_address) + 1'b1) && (slot_number == $past(slot_number)), "sector burst address or slot did not follow on")

	// Any error status is a single-beat result with no transfer.
	`SWSA_ASSERT_NOW(a_error_single, clk, arst_n, result_valid && (status != swsa_pkg::ST_OK), last && (sector_op == swsa_pkg::OP_NONE), "error result carried a transfer or was not final")

endmodule
